FILE: rtl/rau_pkg.sv
`default_nettype none

package rau_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;

  localparam int RES_NUM_W = 32;
  localparam int RES_DEN_W = 31;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_SUM,
    S_GCD,
    S_DIVN_GO,
    S_DIVN_WAIT,
    S_DIVD_GO,
    S_DIVD_WAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/rational_arithmetic_unit_core.sv
// Rational arithmetic unit.
// Input channel: in_tdata carries a_num, a_den, b_num, b_den (OPERAND_WIDTH
// bits each, two's complement), in_tuser the operation (add, sub, mul, div).
// Output channel: out_tdata carries res_num (32 bits) and res_den (31 bits),
// out_tuser the status (ok, zero input denominator, division by zero).
// One result item per input item; in_tready is high only while the
// sequencer is idle, so one item is in work at a time.
// An item with a zero denominator or a zero divisor goes straight to the
// finish state. Otherwise it takes three products on the shared multiplier,
// a binary gcd of subtract/shift steps, and two restoring divisions on the
// shared divider; a zero sum skips the gcd and the divisions.
// The gcd loop and the serial divider take most of the time.
// A finished result sits in the output register; the next item is taken
// while it waits, and the sequencer holds in its last state only if the
// previous result is still not taken. Reset (rst_n low, synchronous)
// returns the sequencer to idle and empties the output register.
`default_nettype none

module rational_arithmetic_unit_core
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // a_num, a_den, b_num, b_den, zero pad
  input  wire logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]   in_tdata,
  // operation
  input  wire logic [1:0]                             in_tuser,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // res_num, res_den, zero pad
  output logic [63:0]                                 out_tdata,
  // status
  output logic [1:0]                                  out_tuser
);

  localparam int W  = OPERAND_WIDTH;
  localparam int MW = 2 * W;
  localparam int KW = $clog2(MW);
  localparam int XW = (MW > 32) ? MW : 33;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    mag_of = v[W-1] ? (~v + W'(1)) : v;
  endfunction

  state_t state_r, state_nxt;

  logic [1:0]   op_r;
  logic [W-1:0] an_m_r, ad_m_r, bn_m_r, bd_m_r;
  logic         an_s_r, ad_s_r, bn_s_r, bd_s_r;
  logic [MW-1:0] prod_r, t1_r, num_m_r, den_m_r;
  logic          t1_s_r, num_s_r, den_s_r;
  logic [MW-1:0] ga_r, gb_r, g_r;
  logic [KW-1:0] gk_r;

  logic [RES_NUM_W-1:0] res_num_r, out_num_r;
  logic [RES_DEN_W-1:0] res_den_r, out_den_r;
  logic [1:0]           res_st_r, out_st_r;
  logic                 out_valid_r;

  logic [W-1:0] in_an, in_ad, in_bn, in_bd;
  logic         in_err_den, in_err_div;
  logic [W-1:0] mul_x, mul_y;
  logic         prod_s;
  logic [MW-1:0] sum_m;
  logic          sum_s;
  logic          out_free;

  div_ctrl_t     div_ctrl;
  div_stat_t     div_stat;
  logic [MW-1:0] div_dividend, div_divisor, div_quo;

  logic          res_neg;
  logic [XW-1:0] nx, nsat, nneg, dx;

  assign in_an = in_tdata[W-1:0];
  assign in_ad = in_tdata[2*W-1:W];
  assign in_bn = in_tdata[3*W-1:2*W];
  assign in_bd = in_tdata[4*W-1:3*W];
  assign in_err_den = (in_ad == '0) || (in_bd == '0);
  assign in_err_div = (in_tuser == OP_DIV) && (in_bn == '0);

  assign out_free = !out_valid_r || out_tready;

  rau_div #(.WIDTH(MW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    in_tready      = 1'b0;
    div_ctrl.start = 1'b0;
    div_dividend   = num_m_r;
    div_divisor    = g_r;
    mul_x          = an_m_r;
    mul_y          = bd_m_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = (in_err_den || in_err_div) ? S_FINISH : S_MUL1;
        end
      end
      S_MUL1: begin
        mul_x     = an_m_r;
        mul_y     = (op_r == OP_MUL) ? bn_m_r : bd_m_r;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        mul_x     = ad_m_r;
        mul_y     = (op_r == OP_DIV) ? bn_m_r : bd_m_r;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        mul_x     = bn_m_r;
        mul_y     = ad_m_r;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        state_nxt = (sum_m == '0) ? S_FINISH : S_GCD;
      end
      S_GCD: begin
        if (ga_r == gb_r) begin
          state_nxt = S_DIVN_GO;
        end
      end
      S_DIVN_GO: begin
        div_ctrl.start = 1'b1;
        div_dividend   = num_m_r;
        state_nxt      = S_DIVN_WAIT;
      end
      S_DIVN_WAIT: begin
        if (div_stat.done) begin
          state_nxt = S_DIVD_GO;
        end
      end
      S_DIVD_GO: begin
        div_ctrl.start = 1'b1;
        div_dividend   = den_m_r;
        state_nxt      = S_DIVD_WAIT;
      end
      S_DIVD_WAIT: begin
        if (div_stat.done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // signed sum of the two cross products for add and sub; mul and div pass the first product
  assign prod_s = bn_s_r ^ ad_s_r ^ (op_r == OP_SUB);
  always_comb begin
    sum_m = t1_r;
    sum_s = t1_s_r;
    if (op_r == OP_ADD || op_r == OP_SUB) begin
      if (t1_s_r == prod_s) begin
        sum_m = t1_r + prod_r;
      end else if (t1_r >= prod_r) begin
        sum_m = t1_r - prod_r;
      end else begin
        sum_m = prod_r - t1_r;
        sum_s = prod_s;
      end
    end
  end

  // saturation of the reduced result
  assign res_neg = num_s_r ^ den_s_r;
  assign nx      = XW'(num_m_r);
  assign dx      = XW'(div_quo);
  always_comb begin
    if (res_neg) begin
      nsat = (nx > XW'(64'h8000_0000)) ? XW'(64'h8000_0000) : nx;
    end else begin
      nsat = (nx > XW'(64'h7FFF_FFFF)) ? XW'(64'h7FFF_FFFF) : nx;
    end
  end
  assign nneg = res_neg ? (~nsat + XW'(1)) : nsat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= MW'(mul_x) * MW'(mul_y);
    unique case (state_r)
      S_IDLE: begin
        op_r   <= in_tuser;
        an_m_r <= mag_of(in_an);
        ad_m_r <= mag_of(in_ad);
        bn_m_r <= mag_of(in_bn);
        bd_m_r <= mag_of(in_bd);
        an_s_r <= in_an[W-1];
        ad_s_r <= in_ad[W-1];
        bn_s_r <= in_bn[W-1];
        bd_s_r <= in_bd[W-1];
        res_num_r <= '0;
        res_den_r <= '0;
        res_st_r  <= in_err_den ? ST_ZERO_DEN : ST_DIV_ZERO;
      end
      S_MUL2: begin
        t1_r   <= prod_r;
        t1_s_r <= an_s_r ^ ((op_r == OP_MUL) ? bn_s_r : bd_s_r);
      end
      S_MUL3: begin
        den_m_r <= prod_r;
        den_s_r <= ad_s_r ^ ((op_r == OP_DIV) ? bn_s_r : bd_s_r);
      end
      S_SUM: begin
        num_m_r   <= sum_m;
        num_s_r   <= sum_s;
        ga_r      <= sum_m;
        gb_r      <= den_m_r;
        gk_r      <= '0;
        res_num_r <= '0;
        res_den_r <= RES_DEN_W'(1);
        res_st_r  <= ST_OK;
      end
      S_GCD: begin
        // binary gcd, one shift or subtract per cycle
        if (ga_r == gb_r) begin
          g_r <= ga_r << gk_r;
        end else if (!ga_r[0] && !gb_r[0]) begin
          ga_r <= ga_r >> 1;
          gb_r <= gb_r >> 1;
          gk_r <= gk_r + KW'(1);
        end else if (!ga_r[0]) begin
          ga_r <= ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_r <= gb_r >> 1;
        end else if (ga_r > gb_r) begin
          ga_r <= ga_r - gb_r;
        end else begin
          gb_r <= gb_r - ga_r;
        end
      end
      S_DIVN_WAIT: begin
        if (div_stat.done) begin
          num_m_r <= div_quo;
        end
      end
      S_DIVD_WAIT: begin
        if (div_stat.done) begin
          res_num_r <= nneg[RES_NUM_W-1:0];
          res_den_r <= (dx > XW'(64'h7FFF_FFFF)) ? RES_DEN_W'(31'h7FFF_FFFF)
                                                 : dx[RES_DEN_W-1:0];
          res_st_r  <= ST_OK;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_num_r <= res_num_r;
          out_den_r <= res_den_r;
          out_st_r  <= res_st_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_den_r, out_num_r};
  assign out_tuser  = out_st_r;

endmodule

`default_nettype wire

FILE: rtl/rau_div.sv
`default_nettype none

module rau_div
  import rau_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire div_ctrl_t        ctrl,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  output div_stat_t             stat,
  output logic      [WIDTH-1:0] quotient
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem_r, quo_r, dvs_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [WIDTH:0]   rs;
  logic [WIDTH:0]   diff;

  // restoring division, one quotient bit per cycle
  assign rs   = {rem_r, quo_r[WIDTH-1]};
  assign diff = rs - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (!diff[WIDTH]) begin
        rem_r <= diff[WIDTH-1:0];
        quo_r <= {quo_r[WIDTH-2:0], 1'b1};
      end else begin
        rem_r <= rs[WIDTH-1:0];
        quo_r <= {quo_r[WIDTH-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

`default_nettype wire
